// File: rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the shared/exclusive lock table.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int SLT_LOCK_ENTRIES = 16;
	localparam int SLT_KEY_BITS     = 32;
	localparam int SLT_KEY_W        = 32;
	localparam int SLT_TID_W        = 16;

	localparam logic [1:0] CMD_ACQUIRE     = 2'd0;
	localparam logic [1:0] CMD_RELEASE     = 2'd1;
	localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;

	localparam logic [2:0] ST_NEW      = 3'd0;
	localparam logic [2:0] ST_HELD     = 3'd1;
	localparam logic [2:0] ST_CONFLICT = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} slt_state_t;

endpackage

// File: rtl/core/shared_exclusive_lock_table_top.sv
// ----------------------------------------------------------------------------
// shared_exclusive_lock_table_top
// Lock table with shared and exclusive modes, scanned one entry per cycle.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall    command, transaction_id, resource_key,
//                                      exclusive
//   out      out  out_valid/out_stall  granted, status
//
// a command is taken from the input, then each entry is read in turn and
// checked by the single key/owner comparator, and a last step decides and
// writes; an undefined command skips the scan and goes to the last step
// after reset a clearing pass over all LOCK_ENTRIES entries resets the valid
// bits, in_stall stays high meanwhile
// in_stall is high whenever a command is in flight; a previous result still
// waiting on out_stall holds the block in its final step until it is taken
// ----------------------------------------------------------------------------
module shared_exclusive_lock_table_top
	import slt_pkg::*;
#(
	parameter int LOCK_ENTRIES = SLT_LOCK_ENTRIES,
	parameter int KEY_BITS     = SLT_KEY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [SLT_TID_W-1:0] transaction_id,
	input  logic [SLT_KEY_W-1:0] resource_key,
	input  logic                 exclusive,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 granted,
	output logic [2:0]           status
);

	localparam int AW   = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
	localparam int SK   = (KEY_BITS < SLT_KEY_W) ? KEY_BITS : SLT_KEY_W;
	localparam int EW   = SK + SLT_TID_W + 2;
	localparam int OWN0 = SK;
	localparam int EXCL = SK + SLT_TID_W;
	localparam int VLD  = SK + SLT_TID_W + 1;
	localparam logic [AW-1:0] LAST = AW'(LOCK_ENTRIES - 1);

	// entry word: valid, exclusive, owner, key
	logic [EW-1:0] mem [LOCK_ENTRIES];
	logic [EW-1:0] mem_rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;

	slt_state_t state_q, state_d;

	logic [1:0]           cmd_q;
	logic [SLT_TID_W-1:0] tid_q;
	logic [SK-1:0]        key_q;
	logic                 excl_q;
	logic [AW-1:0]        addr_q;
	logic                 issue_q;
	logic                 rvalid_q;
	logic [AW-1:0]        ridx_q;
	logic                 held_q;
	logic                 conf_q;
	logic                 free_found_q;
	logic [AW-1:0]        free_idx_q;
	logic                 out_valid_q;
	logic                 granted_q;
	logic [2:0]           status_q;

	logic       accept;
	logic       load_out;
	logic       e_valid, e_excl, e_key_eq, e_own_eq;
	logic       rel_hit, held_hit, conf_hit, free_hit;
	logic       res_granted;
	logic [2:0] res_status;
	logic       res_write;

	assign accept = in_valid && !in_stall;

	// shared compare unit on the entry just read
	assign e_valid  = mem_rdata_q[VLD];
	assign e_excl   = mem_rdata_q[EXCL];
	assign e_key_eq = mem_rdata_q[SK-1:0] == key_q;
	assign e_own_eq = mem_rdata_q[EXCL-1:OWN0] == tid_q;
	assign rel_hit  = e_valid && e_own_eq && ((cmd_q == CMD_RELEASE_ALL) || e_key_eq);
	assign held_hit = e_valid && e_key_eq && e_own_eq;
	assign conf_hit = e_valid && e_key_eq && !e_own_eq && (excl_q || e_excl);
	assign free_hit = !e_valid && !free_found_q;

	always_comb begin
		res_granted = 1'b0;
		res_status  = ST_CONFLICT;
		res_write   = 1'b0;
		case (cmd_q)
			CMD_ACQUIRE: begin
				if (held_q) begin
					res_granted = 1'b1;
					res_status  = ST_HELD;
				end else if (conf_q) begin
					res_status  = ST_CONFLICT;
				end else if (!free_found_q) begin
					res_status  = ST_FULL;
				end else begin
					res_granted = 1'b1;
					res_status  = ST_NEW;
					res_write   = 1'b1;
				end
			end
			CMD_RELEASE, CMD_RELEASE_ALL: begin
				res_granted = 1'b1;
				res_status  = ST_RELEASED;
			end
			default: begin
				res_granted = 1'b0;
				res_status  = ST_CONFLICT;
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		load_out  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		case (state_q)
			FSM_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == LAST) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (command == CMD_ACQUIRE || command == CMD_RELEASE ||
					    command == CMD_RELEASE_ALL) begin
						state_d = FSM_SCAN;
					end else begin
						state_d = FSM_FINISH;
					end
				end
			end
			FSM_SCAN: begin
				if (rvalid_q && cmd_q != CMD_ACQUIRE && rel_hit) begin
					mem_we    = 1'b1;
					mem_waddr = ridx_q;
				end
				if (rvalid_q && ridx_q == LAST) begin
					state_d = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					load_out  = 1'b1;
					state_d   = FSM_IDLE;
					mem_we    = res_write;
					mem_waddr = free_idx_q;
					mem_wdata = {1'b1, excl_q, tid_q, key_q};
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue_q) begin
			mem_rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_CLEAR;
			addr_q       <= '0;
			issue_q      <= 1'b0;
			rvalid_q     <= 1'b0;
			held_q       <= 1'b0;
			conf_q       <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				addr_q <= (addr_q == LAST) ? '0 : addr_q + 1'b1;
			end else if (accept) begin
				addr_q       <= '0;
				issue_q      <= (state_d == FSM_SCAN);
				held_q       <= 1'b0;
				conf_q       <= 1'b0;
				free_found_q <= 1'b0;
			end else if (issue_q) begin
				if (addr_q == LAST) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			rvalid_q <= issue_q;
			if (rvalid_q && cmd_q == CMD_ACQUIRE) begin
				held_q <= held_q || held_hit;
				conf_q <= conf_q || conf_hit;
				if (free_hit) begin
					free_found_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			tid_q  <= transaction_id;
			key_q  <= resource_key[SK-1:0];
			excl_q <= exclusive;
		end
		ridx_q <= addr_q;
		if (rvalid_q && cmd_q == CMD_ACQUIRE && free_hit) begin
			free_idx_q <= ridx_q;
		end
		if (load_out) begin
			granted_q <= res_granted;
			status_q  <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign granted   = granted_q;
	assign status    = status_q;

	// granted agrees with the status code
	a_granted_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (granted_q == (status_q == ST_NEW || status_q == ST_HELD ||
		                               status_q == ST_RELEASED)))
		else $error("granted does not match status");

	// one command at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("new word taken while a command is in flight");

	// read data only evaluated during the scan
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q |-> (state_q == FSM_SCAN))
		else $error("entry read outside of a scan");

	// a new entry only lands in a slot found free
	a_new_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && res_status == ST_NEW) |-> (free_found_q && mem_we))
		else $error("grant without a free slot");

endmodule

// File: bench/tb_shared_exclusive_lock_table_top.sv
// ----------------------------------------------------------------------------
// tb_shared_exclusive_lock_table_top
// Drives acquire, release and release-all words into the lock table and
// checks every reply against a behavioral copy of the table kept in the
// bench. Covers the mode rules, a full table, output back-pressure and long
// randomized traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_shared_exclusive_lock_table_top;
	import slt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNDEFINED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 290;

	typedef struct packed {
		logic       granted;
		logic [2:0] status;
	} lock_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           command = CMD_ACQUIRE;
	logic [SLT_TID_W-1:0] transaction_id = '0;
	logic [SLT_KEY_W-1:0] resource_key = '0;
	logic                 exclusive = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 granted;
	logic [2:0]           status;

	// bench copy of the lock table
	logic                 lock_valid [SLT_LOCK_ENTRIES];
	logic [SLT_KEY_W-1:0] lock_key   [SLT_LOCK_ENTRIES];
	logic [SLT_TID_W-1:0] lock_owner [SLT_LOCK_ENTRIES];
	logic                 lock_excl  [SLT_LOCK_ENTRIES];

	lock_reply_t pending_replies [$];
	lock_reply_t oldest_reply;

	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	shared_exclusive_lock_table_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.transaction_id (transaction_id),
		.resource_key   (resource_key),
		.exclusive      (exclusive),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted        (granted),
		.status         (status)
	);

	always #5 clk = ~clk;

	function automatic lock_reply_t lock_table_apply(input logic [1:0] cmd,
			input logic [SLT_TID_W-1:0] tid, input logic [SLT_KEY_W-1:0] key,
			input logic excl);
		lock_reply_t reply;
		int free_idx;
		logic held;
		logic clash;
		reply.granted = 1'b0;
		reply.status = ST_CONFLICT;
		free_idx = -1;
		held = 1'b0;
		clash = 1'b0;
		case (cmd)
			CMD_ACQUIRE: begin
				for (int i = 0; i < SLT_LOCK_ENTRIES; i++) begin
					if (!lock_valid[i]) begin
						if (free_idx < 0)
							free_idx = i;
					end else if (lock_key[i] == key) begin
						if (lock_owner[i] == tid)
							held = 1'b1;
						else if (excl || lock_excl[i])
							clash = 1'b1;
					end
				end
				// a lock already held wins over any conflict or a full table
				if (held) begin
					reply.granted = 1'b1;
					reply.status = ST_HELD;
				end else if (clash) begin
					reply.status = ST_CONFLICT;
				end else if (free_idx < 0) begin
					reply.status = ST_FULL;
				end else begin
					lock_valid[free_idx] = 1'b1;
					lock_key[free_idx] = key;
					lock_owner[free_idx] = tid;
					lock_excl[free_idx] = excl;
					reply.granted = 1'b1;
					reply.status = ST_NEW;
				end
			end
			CMD_RELEASE, CMD_RELEASE_ALL: begin
				for (int i = 0; i < SLT_LOCK_ENTRIES; i++) begin
					if (lock_valid[i] && lock_owner[i] == tid &&
							(cmd == CMD_RELEASE_ALL || lock_key[i] == key)) begin
						lock_valid[i] = 1'b0;
						lock_key[i] = '0;
						lock_owner[i] = '0;
						lock_excl[i] = 1'b0;
					end
				end
				reply.granted = 1'b1;
				reply.status = ST_RELEASED;
			end
			default: begin
				reply.granted = 1'b0;
				reply.status = ST_CONFLICT;
			end
		endcase
		return reply;
	endfunction

	task automatic send_word(input logic [1:0] cmd, input logic [SLT_TID_W-1:0] tid,
			input logic [SLT_KEY_W-1:0] key, input logic excl);
		int gap;
		lock_reply_t expected;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 200)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		transaction_id <= tid;
		resource_key <= key;
		exclusive <= excl;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected = lock_table_apply(cmd, tid, key, excl);
		pending_replies.insert(pending_replies.size(), expected);
	endtask

	// sender goes quiet until every reply is back
	task automatic drain_replies();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	task automatic release_every_owner();
		int idx;
		idx = 0;
		while (idx < SLT_LOCK_ENTRIES) begin
			if (lock_valid[idx])
				send_word(CMD_RELEASE_ALL, lock_owner[idx], $urandom,
					1'($urandom_range(1)));
			else
				idx++;
		end
	endtask

	task automatic test_mode_rules();
		logic [SLT_TID_W-1:0] ta, tb, tc;
		logic [SLT_KEY_W-1:0] k1, k2;
		ta = 16'h0000;
		tb = 16'hFFFF;
		tc = 16'h5A5A;
		k1 = 32'h0000_0000;
		k2 = 32'hFFFF_FFFF;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_word(CMD_ACQUIRE, ta, k1, 1'b0);
		send_word(CMD_ACQUIRE, ta, k1, 1'b0);
		// same owner asking exclusive keeps the shared lock
		send_word(CMD_ACQUIRE, ta, k1, 1'b1);
		send_word(CMD_ACQUIRE, tb, k1, 1'b0);
		send_word(CMD_ACQUIRE, tc, k1, 1'b1);
		send_word(CMD_ACQUIRE, tb, k1, 1'b1);
		send_word(CMD_ACQUIRE, tc, k2, 1'b1);
		send_word(CMD_ACQUIRE, ta, k2, 1'b0);
		send_word(CMD_ACQUIRE, ta, k2, 1'b1);
		send_word(CMD_ACQUIRE, tc, k2, 1'b0);
		// release of a key not held
		send_word(CMD_RELEASE, tb, k2, 1'b1);
		send_word(CMD_RELEASE, ta, k1, 1'b0);
		send_word(CMD_ACQUIRE, tc, k1, 1'b1);
		send_word(CMD_RELEASE_ALL, tb, k2, 1'b1);
		send_word(CMD_ACQUIRE, tc, k1, 1'b1);
		send_word(CMD_RELEASE_ALL, 16'h1234, k1, 1'b0);
		send_word(CMD_UNDEFINED, ta, k1, 1'b1);
		send_word(CMD_UNDEFINED, tb, k2, 1'b0);
		send_word(CMD_RELEASE_ALL, tc, k2, 1'b0);
		send_word(CMD_RELEASE_ALL, ta, k1, 1'b0);
		drain_replies();
	endtask

	task automatic test_table_full();
		logic [SLT_TID_W-1:0] owner, rival;
		logic [SLT_KEY_W-1:0] base;
		owner = SLT_TID_W'($urandom_range(16'hFFFF));
		rival = owner ^ 16'h8001;
		base = $urandom;
		send_idle_pct = 26;
		recv_stall_pct = 26;
		release_every_owner();
		for (int i = 0; i < SLT_LOCK_ENTRIES; i++)
			send_word(CMD_ACQUIRE, owner, base + i, i[0]);
		send_word(CMD_ACQUIRE, owner, base + SLT_LOCK_ENTRIES, 1'b0);
		send_word(CMD_ACQUIRE, owner, base + 3, 1'b0);
		// shared on a shared entry still needs a slot of its own
		send_word(CMD_ACQUIRE, rival, base, 1'b0);
		send_word(CMD_ACQUIRE, rival, base + 1, 1'b0);
		send_word(CMD_RELEASE, owner, base + 5, 1'b0);
		send_word(CMD_ACQUIRE, rival, base + SLT_LOCK_ENTRIES, 1'b1);
		send_word(CMD_ACQUIRE, owner, base + SLT_LOCK_ENTRIES + 1, 1'b1);
		send_word(CMD_RELEASE_ALL, owner, base, 1'b0);
		send_word(CMD_RELEASE_ALL, rival, base, 1'b1);
		drain_replies();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left <= HOLD_OFF_CYCLES;
		for (int i = 0; i < 14; i++)
			send_word(i[1:0] == CMD_UNDEFINED ? CMD_ACQUIRE : i[1:0],
				SLT_TID_W'($urandom_range(3)), $urandom_range(5),
				1'($urandom_range(1)));
		drain_replies();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int count);
		logic [SLT_TID_W-1:0] tid_pool [6];
		logic [SLT_KEY_W-1:0] key_pool [8];
		int pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		foreach (tid_pool[i])
			tid_pool[i] = SLT_TID_W'($urandom_range(16'hFFFF));
		foreach (key_pool[i])
			key_pool[i] = $urandom;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 55)
				send_word(CMD_ACQUIRE, tid_pool[$urandom_range(5)],
					key_pool[$urandom_range(7)], 1'($urandom_range(1)));
			else if (pick < 75)
				send_word(CMD_RELEASE, tid_pool[$urandom_range(5)],
					key_pool[$urandom_range(7)], 1'($urandom_range(1)));
			else if (pick < 83)
				send_word(CMD_RELEASE_ALL, tid_pool[$urandom_range(5)], $urandom,
					1'($urandom_range(1)));
			else if (pick < 96)
				send_word(2'($urandom_range(2)), SLT_TID_W'($urandom_range(16'hFFFF)),
					$urandom, 1'($urandom_range(1)));
			else
				send_word(CMD_UNDEFINED, SLT_TID_W'($urandom_range(16'hFFFF)),
					$urandom, 1'($urandom_range(1)));
		end
		drain_replies();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply, granted %0d status %0d",
					$time, granted, status);
				fail_count++;
			end else begin
				oldest_reply = pending_replies.pop_front();
				if (granted !== oldest_reply.granted) begin
					$display("%0t: granted mismatch, expected %0d actual %0d",
						$time, oldest_reply.granted, granted);
					fail_count++;
				end
				if (status !== oldest_reply.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d",
						$time, oldest_reply.status, status);
					fail_count++;
				end
			end
		end
	end

	// stall watchdog: no word moving on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, %0d replies outstanding", $time,
				pending_replies.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SLT_LOCK_ENTRIES; i++) begin
			lock_valid[i] = 1'b0;
			lock_key[i] = '0;
			lock_owner[i] = '0;
			lock_excl[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mode_rules();
		test_table_full();
		test_backpressure();
		test_random_traffic(0, 0, ITEMS_PER_PHASE);
		test_random_traffic(63, 0, ITEMS_PER_PHASE);
		test_random_traffic(0, 63, ITEMS_PER_PHASE);
		test_random_traffic(26, 26, ITEMS_PER_PHASE);
		repeat (SLT_LOCK_ENTRIES + 8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/slt_pkg.sv
rtl/core/shared_exclusive_lock_table_top.sv
bench/tb_shared_exclusive_lock_table_top.sv
